// File: rtl/core/rwlm_pkg.sv
// Shared types, constants and a helper function for the receive window loss monitor.
// No dependencies; every other file in the block imports this package.
`default_nettype none
package rwlm_pkg;

  localparam int SEQ_W   = 16;
  localparam int TIME_W  = 32;
  localparam int BYTES_W = 16;
  localparam int WLEN_W  = 24;
  localparam int WB_W    = 32;
  localparam int RUN_W   = 17;
  localparam int RATE_W  = 17;
  localparam int LOSS_W  = 21;
  localparam int NCNT_W  = 6;

  localparam logic [NCNT_W-1:0] MAX_BODY_RESULTS = 6'd47;
  localparam logic [WLEN_W-1:0] WLEN_RESET       = 24'd1000000;
  localparam logic [SEQ_W-1:0]  LAST_SEQ_RESET   = 16'hFFFF;
  localparam logic [RATE_W-1:0] RATE_ONE         = 17'h10000;

  localparam int DIV_NW  = 45;
  localparam int DIV_DW  = 24;
  localparam int DIV_CW  = $clog2(DIV_NW + 1);
  localparam logic [DIV_NW-1:0] BITS_PER_BYTE_MS = 45'd8000;

  localparam logic [1:0] KIND_LOSS    = 2'd0;
  localparam logic [1:0] KIND_SAMPLE  = 2'd1;
  localparam logic [1:0] KIND_SUMMARY = 2'd2;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_RIGHT,
    OP_LEFT,
    OP_LOAD
  } cell_op_e;

  typedef struct packed {
    logic [SEQ_W-1:0]   seq;
    logic [TIME_W-1:0]  tstamp;
    logic [BYTES_W-1:0] nbytes;
  } rec_t;

  function automatic logic serial_before(input logic [SEQ_W-1:0] a,
                                         input logic [SEQ_W-1:0] b);
    logic [SEQ_W-1:0] fwd;
    logic [SEQ_W-1:0] back;
    fwd  = b - a;
    back = a - b;
    return fwd < back;
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/receive_window_loss_monitor.sv
// Receive window loss monitor top level: record cell chain, sequencer and output register.
// Arrival: busy through the eviction of each expired record, then order, drop when full, insert.
// Report: walks the runs and gaps, then the samples, then up to two passes of the shared
// serial divider (throughput, then loss rate); output stalls hold the walk.
// One item is in work at a time; a result waits in the output register without blocking input.
// Reset is asynchronous and active low; the record cells are not cleared, the count is.
`default_nettype none
module receive_window_loss_monitor
  import rwlm_pkg::*;
#(
  parameter int STORE_DEPTH = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [WLEN_W-1:0]  cfg_wdata_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic               mode_i,
  input  wire logic [SEQ_W-1:0]   seq_number_i,
  input  wire logic [TIME_W-1:0]  arrival_time_i,
  input  wire logic [BYTES_W-1:0] packet_bytes_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [1:0]              kind_o,
  output logic [RUN_W-1:0]        run_value_o,
  output logic [SEQ_W-1:0]        sample_seq_o,
  output logic [TIME_W-1:0]       sample_time_o,
  output logic [BYTES_W-1:0]      sample_bytes_o,
  output logic [SEQ_W-1:0]        packet_span_o,
  output logic [SEQ_W-1:0]        loss_count_o,
  output logic [TIME_W-1:0]       throughput_o,
  output logic [RATE_W-1:0]       loss_rate_q16_o,
  output logic                    last_o
);

  localparam int IW = $clog2(STORE_DEPTH);
  localparam int CW = $clog2(STORE_DEPTH + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_EVICT = 4'd1;
  localparam logic [3:0] S_ORDER = 4'd2;
  localparam logic [3:0] S_DROP  = 4'd3;
  localparam logic [3:0] S_INS   = 4'd4;
  localparam logic [3:0] S_RUN   = 4'd5;
  localparam logic [3:0] S_GAP   = 4'd6;
  localparam logic [3:0] S_SAMP  = 4'd7;
  localparam logic [3:0] S_MUL   = 4'd8;
  localparam logic [3:0] S_DIVT  = 4'd9;
  localparam logic [3:0] S_DIVL  = 4'd10;
  localparam logic [3:0] S_SUM   = 4'd11;

  logic [3:0]          state_q;
  logic [WLEN_W-1:0]   wl_q;
  logic [SEQ_W-1:0]    seq_q;
  logic [TIME_W-1:0]   time_q;
  logic [BYTES_W-1:0]  bytes_q;
  logic                evict_en_q;
  logic [CW-1:0]       count_q;
  logic [CW-1:0]       pos_q;
  logic [IW-1:0]       idx_q;
  logic [WB_W-1:0]     wb_q;
  logic [SEQ_W-1:0]    last_rep_q;
  logic [RATE_W-1:0]   held_rate_q;
  logic [SEQ_W-1:0]    prev_q;
  logic [SEQ_W-1:0]    first_q;
  logic [RUN_W-1:0]    consec_q;
  logic [RUN_W-1:0]    gap_q;
  logic [LOSS_W-1:0]   loss_q;
  logic [SEQ_W-1:0]    span_q;
  logic [NCNT_W-1:0]   n_q;
  logic [TIME_W-1:0]   thr_q;

  logic                ov_q;
  logic [1:0]          kind_q;
  logic [RUN_W-1:0]    run_q;
  logic [SEQ_W-1:0]    sseq_q;
  logic [TIME_W-1:0]   stime_q;
  logic [BYTES_W-1:0]  sbytes_q;
  logic [SEQ_W-1:0]    ospan_q;
  logic [SEQ_W-1:0]    oloss_q;
  logic [TIME_W-1:0]   othr_q;
  logic [RATE_W-1:0]   orate_q;
  logic                olast_q;

  rec_t                cell_rec [STORE_DEPTH];
  cell_op_e            cell_op  [STORE_DEPTH];
  rec_t                new_rec;
  rec_t                rd_rec;
  logic [IW-1:0]       rd_addr;

  logic [TIME_W-1:0]   limit;
  logic                evict_any;
  logic [IW-1:0]       evict_k;
  logic                dup_any;
  logic                bef_any;
  logic [CW-1:0]       pos_hi;
  logic                rd_last;
  logic [SEQ_W-1:0]    d_w;
  logic                cap_ok;
  logic                can_emit;
  logic                stall;
  logic [DIV_NW-1:0]   prod_w;
  logic                div_start;
  logic [DIV_NW-1:0]   div_dividend;
  logic [DIV_DW-1:0]   div_divisor;
  logic                div_done;
  logic [DIV_NW-1:0]   div_q;

  assign new_rec = '{seq: seq_q, tstamp: time_q, nbytes: bytes_q};
  assign limit   = time_q - {{(TIME_W-WLEN_W){1'b0}}, wl_q};
  assign rd_addr = (state_q == S_EVICT) ? evict_k : idx_q;
  assign rd_rec  = cell_rec[rd_addr];
  assign rd_last = ({1'b0, idx_q} == CW'(count_q - 1'b1));
  assign d_w     = rd_rec.seq - prev_q;
  assign cap_ok  = n_q < MAX_BODY_RESULTS;
  assign can_emit = !ov_q || out_ready_i;
  assign stall   = cap_ok && !can_emit;
  assign prod_w  = {{(DIV_NW-WB_W){1'b0}}, wb_q} * BITS_PER_BYTE_MS;

  always_comb begin
    evict_any = 1'b0;
    evict_k   = '0;
    dup_any   = 1'b0;
    bef_any   = 1'b0;
    pos_hi    = '0;
    for (int j = STORE_DEPTH - 1; j >= 0; j--) begin
      if ((CW'(j) < count_q) && evict_en_q && (cell_rec[j].tstamp < limit)) begin
        evict_any = 1'b1;
        evict_k   = IW'(j);
      end
    end
    for (int j = 0; j < STORE_DEPTH; j++) begin
      if (CW'(j) < count_q) begin
        if (cell_rec[j].seq == seq_q) begin
          dup_any = 1'b1;
        end
        if (serial_before(cell_rec[j].seq, seq_q)) begin
          bef_any = 1'b1;
          pos_hi  = CW'(j + 1);
        end
      end
    end
  end

  always_comb begin
    for (int j = 0; j < STORE_DEPTH; j++) begin
      cell_op[j] = OP_HOLD;
      case (state_q)
        S_EVICT: begin
          if (evict_any && (IW'(j) >= evict_k)) begin
            cell_op[j] = OP_RIGHT;
          end
        end
        S_DROP: begin
          cell_op[j] = OP_RIGHT;
        end
        S_INS: begin
          if (CW'(j) == pos_q) begin
            cell_op[j] = OP_LOAD;
          end else if (CW'(j) > pos_q) begin
            cell_op[j] = OP_LEFT;
          end
        end
        default: begin
          cell_op[j] = OP_HOLD;
        end
      endcase
    end
  end

  for (genvar g = 0; g < STORE_DEPTH; g++) begin : g_cell
    rec_t left_w;
    rec_t right_w;
    if (g == 0) begin : g_first
      assign left_w = new_rec;
    end else begin : g_mid_l
      assign left_w = cell_rec[g-1];
    end
    if (g == STORE_DEPTH - 1) begin : g_tail
      assign right_w = cell_rec[g];
    end else begin : g_mid_r
      assign right_w = cell_rec[g+1];
    end
    rwlm_cell u_cell (
      .clk_i   (clk_i),
      .op_i    (cell_op[g]),
      .left_i  (left_w),
      .right_i (right_w),
      .new_i   (new_rec),
      .rec_o   (cell_rec[g])
    );
  end

  always_comb begin
    div_start    = 1'b0;
    div_dividend = prod_w;
    div_divisor  = wl_q;
    if ((state_q == S_MUL) && (wl_q != '0)) begin
      div_start = 1'b1;
    end
    if ((((state_q == S_DIVT) && div_done) || ((state_q == S_MUL) && (wl_q == '0))) &&
        (span_q != '0)) begin
      div_start    = 1'b1;
      div_dividend = DIV_NW'({loss_q, 16'h0000});
      div_divisor  = {{(DIV_DW-SEQ_W){1'b0}}, span_q};
    end
  end

  rwlm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wl_q        <= WLEN_RESET;
      seq_q       <= '0;
      time_q      <= '0;
      bytes_q     <= '0;
      evict_en_q  <= 1'b0;
      count_q     <= '0;
      pos_q       <= '0;
      idx_q       <= '0;
      wb_q        <= '0;
      last_rep_q  <= LAST_SEQ_RESET;
      held_rate_q <= '0;
      prev_q      <= '0;
      first_q     <= '0;
      consec_q    <= '0;
      gap_q       <= '0;
      loss_q      <= '0;
      span_q      <= '0;
      n_q         <= '0;
      thr_q       <= '0;
      ov_q        <= 1'b0;
      kind_q      <= '0;
      run_q       <= '0;
      sseq_q      <= '0;
      stime_q     <= '0;
      sbytes_q    <= '0;
      ospan_q     <= '0;
      oloss_q     <= '0;
      othr_q      <= '0;
      orate_q     <= '0;
      olast_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        wl_q <= cfg_wdata_i;
      end
      if (ov_q && out_ready_i) begin
        ov_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            seq_q      <= seq_number_i;
            time_q     <= arrival_time_i;
            bytes_q    <= packet_bytes_i;
            evict_en_q <= arrival_time_i >= {{(TIME_W-WLEN_W){1'b0}}, wl_q};
            idx_q      <= '0;
            consec_q   <= '0;
            loss_q     <= '0;
            span_q     <= '0;
            n_q        <= '0;
            if (!mode_i) begin
              wb_q    <= wb_q + {{(WB_W-BYTES_W){1'b0}}, packet_bytes_i};
              state_q <= S_EVICT;
            end else if (count_q != '0) begin
              prev_q  <= cell_rec[0].seq - 1'b1;
              state_q <= S_RUN;
            end else begin
              state_q <= S_MUL;
            end
          end
        end
        S_EVICT: begin
          if (evict_any) begin
            wb_q    <= wb_q - {{(WB_W-BYTES_W){1'b0}}, rd_rec.nbytes};
            count_q <= count_q - 1'b1;
          end else begin
            state_q <= S_ORDER;
          end
        end
        S_ORDER: begin
          if (dup_any) begin
            state_q <= S_IDLE;
          end else if ((count_q == '0) || serial_before(seq_q, cell_rec[0].seq)) begin
            pos_q   <= '0;
            state_q <= (count_q == CW'(STORE_DEPTH)) ? S_DROP : S_INS;
          end else if (bef_any) begin
            pos_q   <= pos_hi;
            state_q <= (count_q == CW'(STORE_DEPTH)) ? S_DROP : S_INS;
          end else begin
            state_q <= S_IDLE;
          end
        end
        S_DROP: begin
          wb_q    <= wb_q - {{(WB_W-BYTES_W){1'b0}}, cell_rec[0].nbytes};
          count_q <= count_q - 1'b1;
          if (pos_q != '0) begin
            pos_q <= pos_q - 1'b1;
          end
          state_q <= S_INS;
        end
        S_INS: begin
          count_q <= count_q + 1'b1;
          state_q <= S_IDLE;
        end
        S_RUN: begin
          if (!(((d_w != 16'd1) || rd_last) && stall)) begin
            if (idx_q == '0) begin
              first_q <= rd_rec.seq;
            end
            if (rd_last && (count_q > CW'(1))) begin
              span_q <= rd_rec.seq - ((idx_q == '0) ? rd_rec.seq : first_q) + 1'b1;
            end
            prev_q <= rd_rec.seq;
            if (d_w == 16'd1) begin
              consec_q <= consec_q + 1'b1;
              if (rd_last) begin
                if (cap_ok) begin
                  ov_q    <= 1'b1;
                  kind_q  <= KIND_LOSS;
                  run_q   <= consec_q + 1'b1;
                  sseq_q  <= '0;
                  stime_q <= '0;
                  sbytes_q <= '0;
                  ospan_q <= '0;
                  oloss_q <= '0;
                  othr_q  <= '0;
                  orate_q <= '0;
                  olast_q <= 1'b0;
                  n_q     <= n_q + 1'b1;
                end
                idx_q   <= '0;
                state_q <= S_SAMP;
              end else begin
                idx_q <= idx_q + 1'b1;
              end
            end else begin
              if (cap_ok) begin
                ov_q    <= 1'b1;
                kind_q  <= KIND_LOSS;
                run_q   <= consec_q;
                sseq_q  <= '0;
                stime_q <= '0;
                sbytes_q <= '0;
                ospan_q <= '0;
                oloss_q <= '0;
                othr_q  <= '0;
                orate_q <= '0;
                olast_q <= 1'b0;
                n_q     <= n_q + 1'b1;
              end
              gap_q    <= RUN_W'(1) - {1'b0, d_w};
              loss_q   <= loss_q + {{(LOSS_W-SEQ_W){1'b0}}, SEQ_W'(d_w - 1'b1)};
              consec_q <= RUN_W'(1);
              state_q  <= S_GAP;
            end
          end
        end
        S_GAP: begin
          if (!stall) begin
            if (cap_ok) begin
              ov_q    <= 1'b1;
              kind_q  <= KIND_LOSS;
              run_q   <= gap_q;
              sseq_q  <= '0;
              stime_q <= '0;
              sbytes_q <= '0;
              ospan_q <= '0;
              oloss_q <= '0;
              othr_q  <= '0;
              orate_q <= '0;
              olast_q <= 1'b0;
              n_q     <= n_q + 1'b1;
            end
            if (rd_last) begin
              idx_q   <= '0;
              state_q <= S_SAMP;
            end else begin
              idx_q   <= idx_q + 1'b1;
              state_q <= S_RUN;
            end
          end
        end
        S_SAMP: begin
          if (!(serial_before(last_rep_q, rd_rec.seq) && stall)) begin
            if (serial_before(last_rep_q, rd_rec.seq)) begin
              last_rep_q <= rd_rec.seq;
              if (cap_ok) begin
                ov_q    <= 1'b1;
                kind_q  <= KIND_SAMPLE;
                run_q   <= '0;
                sseq_q  <= rd_rec.seq;
                stime_q <= rd_rec.tstamp;
                sbytes_q <= rd_rec.nbytes;
                ospan_q <= '0;
                oloss_q <= '0;
                othr_q  <= '0;
                orate_q <= '0;
                olast_q <= 1'b0;
                n_q     <= n_q + 1'b1;
              end
            end
            if (rd_last) begin
              state_q <= S_MUL;
            end else begin
              idx_q <= idx_q + 1'b1;
            end
          end
        end
        S_MUL: begin
          if (wl_q == '0) begin
            thr_q <= (wb_q != '0) ? {TIME_W{1'b1}} : '0;
            state_q <= (span_q != '0) ? S_DIVL : S_SUM;
          end else begin
            state_q <= S_DIVT;
          end
        end
        S_DIVT: begin
          if (div_done) begin
            thr_q   <= (div_q[DIV_NW-1:TIME_W] != '0) ? {TIME_W{1'b1}} : div_q[TIME_W-1:0];
            state_q <= (span_q != '0) ? S_DIVL : S_SUM;
          end
        end
        S_DIVL: begin
          if (div_done) begin
            held_rate_q <= (div_q > DIV_NW'(RATE_ONE)) ? RATE_ONE : div_q[RATE_W-1:0];
            state_q     <= S_SUM;
          end
        end
        S_SUM: begin
          if (can_emit) begin
            ov_q     <= 1'b1;
            kind_q   <= KIND_SUMMARY;
            run_q    <= '0;
            sseq_q   <= '0;
            stime_q  <= '0;
            sbytes_q <= '0;
            ospan_q  <= span_q;
            oloss_q  <= (loss_q[LOSS_W-1:SEQ_W] != '0) ? {SEQ_W{1'b1}} : loss_q[SEQ_W-1:0];
            othr_q   <= thr_q;
            orate_q  <= held_rate_q;
            olast_q  <= 1'b1;
            state_q  <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o      = (state_q == S_IDLE);
  assign out_valid_o     = ov_q;
  assign kind_o          = kind_q;
  assign run_value_o     = run_q;
  assign sample_seq_o    = sseq_q;
  assign sample_time_o   = stime_q;
  assign sample_bytes_o  = sbytes_q;
  assign packet_span_o   = ospan_q;
  assign loss_count_o    = oloss_q;
  assign throughput_o    = othr_q;
  assign loss_rate_q16_o = orate_q;
  assign last_o          = olast_q;

endmodule
`default_nettype wire

// File: rtl/core/rwlm_cell.sv
// One storage cell of the record chain: holds a record, takes a neighbor's record or loads the new one.
// Depends on rwlm_pkg for the record type and the cell operation codes.
`default_nettype none
module rwlm_cell
  import rwlm_pkg::*;
(
  input  wire logic     clk_i,
  input  wire cell_op_e op_i,
  input  wire rec_t     left_i,
  input  wire rec_t     right_i,
  input  wire rec_t     new_i,
  output rec_t          rec_o
);

  rec_t rec_q;
  rec_t rec_d;

  always_comb begin
    case (op_i)
      OP_RIGHT: rec_d = right_i;
      OP_LEFT:  rec_d = left_i;
      OP_LOAD:  rec_d = new_i;
      default:  rec_d = rec_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

  assign rec_o = rec_q;

endmodule
`default_nettype wire

// File: rtl/core/rwlm_div.sv
// Restoring divider that retires one quotient bit per cycle.
// Depends on rwlm_pkg for the operand widths.
`default_nettype none
module rwlm_div
  import rwlm_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [DIV_NW-1:0] dividend_i,
  input  wire logic [DIV_DW-1:0] divisor_i,
  output logic                   done_o,
  output logic      [DIV_NW-1:0] quotient_o
);

  logic [DIV_NW-1:0] q_q;
  logic [DIV_DW:0]   r_q;
  logic [DIV_DW-1:0] div_q;
  logic [DIV_CW-1:0] cnt_q;
  logic              busy_q;
  logic              done_q;
  logic [DIV_DW:0]   r_sh;
  logic              ge;

  assign r_sh = {r_q[DIV_DW-1:0], q_q[DIV_NW-1]};
  assign ge   = r_sh >= {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      q_q    <= '0;
      r_q    <= '0;
      div_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        q_q    <= dividend_i;
        r_q    <= '0;
        div_q  <= divisor_i;
      end else if (busy_q) begin
        r_q   <= ge ? (r_sh - {1'b0, div_q}) : r_sh;
        q_q   <= {q_q[DIV_NW-2:0], ge};
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DIV_CW'(DIV_NW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = q_q;

endmodule
`default_nettype wire

// File: rtl/core/rwlm_checker.sv
// Port-level checks for the receive window loss monitor, bound to its top level.
// Depends on rwlm_pkg for field widths and result kind codes.
`default_nettype none
module rwlm_checker
  import rwlm_pkg::*;
(
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_ready_o,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire logic [1:0]         kind_o,
  input wire logic [RUN_W-1:0]   run_value_o,
  input wire logic [SEQ_W-1:0]   sample_seq_o,
  input wire logic [TIME_W-1:0]  throughput_o,
  input wire logic [RATE_W-1:0]  loss_rate_q16_o,
  input wire logic               last_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(run_value_o) && $stable(kind_o))
    else $error("Stalled result changed before its transfer.");

  a_last_summary: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_o == (kind_o == KIND_SUMMARY)))
    else $error("Last flag does not match the summary kind.");

  a_loss_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_LOSS |-> sample_seq_o == '0 && throughput_o == '0)
    else $error("Loss entry carries nonzero sample or summary fields.");

  a_busy_after_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("Input accepted again in the cycle after a transfer.");

  a_rate_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |-> loss_rate_q16_o <= RATE_ONE)
    else $error("Loss rate exceeds one in Q16.");

endmodule

bind receive_window_loss_monitor rwlm_checker u_rwlm_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .kind_o          (kind_o),
  .run_value_o     (run_value_o),
  .sample_seq_o    (sample_seq_o),
  .throughput_o    (throughput_o),
  .loss_rate_q16_o (loss_rate_q16_o),
  .last_o          (last_o)
);
`default_nettype wire

// File: test/rwlm_checker.sv
// Checker for the receive window loss monitor: watches the configuration port and both
// handshake channels, predicts every report result and compares it. Depends on rwlm_pkg.
`timescale 1ns / 1ps
package rwlm_tb_pkg;
  localparam logic MODE_ARRIVAL = 1'b0;
  localparam logic MODE_REPORT  = 1'b1;
endpackage

module rwlm_tb_monitor
  import rwlm_pkg::*;
  import rwlm_tb_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [WLEN_W-1:0]  cfg_wdata_i,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic               mode_i,
  input  logic [SEQ_W-1:0]   seq_number_i,
  input  logic [TIME_W-1:0]  arrival_time_i,
  input  logic [BYTES_W-1:0] packet_bytes_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic [1:0]         kind_i,
  input  logic [RUN_W-1:0]   run_value_i,
  input  logic [SEQ_W-1:0]   sample_seq_i,
  input  logic [TIME_W-1:0]  sample_time_i,
  input  logic [BYTES_W-1:0] sample_bytes_i,
  input  logic [SEQ_W-1:0]   packet_span_i,
  input  logic [SEQ_W-1:0]   loss_count_i,
  input  logic [TIME_W-1:0]  throughput_i,
  input  logic [RATE_W-1:0]  loss_rate_q16_i,
  input  logic               last_i,
  output int                 errors_o,
  output int                 pending_o,
  output int                 results_o,
  output int                 reports_o
);

  localparam int DEPTH = 16;

  typedef struct packed {
    logic [1:0]         kind;
    logic [RUN_W-1:0]   run;
    logic [SEQ_W-1:0]   sseq;
    logic [TIME_W-1:0]  stime;
    logic [BYTES_W-1:0] sbytes;
    logic [SEQ_W-1:0]   span;
    logic [SEQ_W-1:0]   loss;
    logic [TIME_W-1:0]  thr;
    logic [RATE_W-1:0]  rate;
    logic               last;
  } report_word_t;

  logic [SEQ_W-1:0]   rec_seq[DEPTH];
  logic [TIME_W-1:0]  rec_time[DEPTH];
  logic [BYTES_W-1:0] rec_bytes[DEPTH];
  int                 rec_count;
  logic [WB_W-1:0]    win_bytes;
  logic [SEQ_W-1:0]   last_seq;
  logic [RATE_W-1:0]  held_rate;
  logic [WLEN_W-1:0]  wlen;
  int                 body_count;
  int                 errors;
  int                 results;
  int                 reports;
  report_word_t       pending_results[$];

  function automatic bit seq_precedes(logic [SEQ_W-1:0] a, logic [SEQ_W-1:0] b);
    logic [SEQ_W-1:0] fwd;
    logic [SEQ_W-1:0] back;
    fwd  = b - a;
    back = a - b;
    return fwd < back;
  endfunction

  function automatic void drop_record(int pos);
    for (int i = pos; i + 1 < rec_count; i++) begin
      rec_seq[i]   = rec_seq[i+1];
      rec_time[i]  = rec_time[i+1];
      rec_bytes[i] = rec_bytes[i+1];
    end
    rec_count--;
  endfunction

  function automatic void apply_arrival(logic [SEQ_W-1:0] s, logic [TIME_W-1:0] now,
                                        logic [BYTES_W-1:0] nb);
    int i;
    int pos;
    bit placed;
    logic [TIME_W-1:0] limit;
    if (now >= TIME_W'(wlen)) begin
      limit = now - TIME_W'(wlen);
      i = 0;
      while (i < rec_count) begin
        if (rec_time[i] < limit) begin
          win_bytes -= WB_W'(rec_bytes[i]);
          drop_record(i);
        end else begin
          i++;
        end
      end
    end
    win_bytes += WB_W'(nb);
    for (i = 0; i < rec_count; i++)
      if (rec_seq[i] == s) return;
    pos = 0;
    placed = 0;
    if (rec_count == 0 || seq_precedes(s, rec_seq[0])) begin
      placed = 1;
    end else begin
      for (i = rec_count; i > 0; i--) begin
        if (seq_precedes(rec_seq[i-1], s)) begin
          pos = i;
          placed = 1;
          break;
        end
      end
    end
    if (!placed) return;
    if (rec_count >= DEPTH) begin
      win_bytes -= WB_W'(rec_bytes[0]);
      drop_record(0);
      if (pos > 0) pos--;
    end
    for (i = rec_count; i > pos; i--) begin
      rec_seq[i]   = rec_seq[i-1];
      rec_time[i]  = rec_time[i-1];
      rec_bytes[i] = rec_bytes[i-1];
    end
    rec_seq[pos]   = s;
    rec_time[pos]  = now;
    rec_bytes[pos] = nb;
    rec_count++;
  endfunction

  function automatic void append_expected(report_word_t w);
    pending_results.insert(pending_results.size(), w);
  endfunction

  function automatic void push_body(logic [1:0] k, logic [RUN_W-1:0] run,
                                    logic [SEQ_W-1:0] s, logic [TIME_W-1:0] t,
                                    logic [BYTES_W-1:0] b);
    report_word_t w;
    if (body_count >= int'(MAX_BODY_RESULTS)) return;
    w = '0;
    w.kind   = k;
    w.run    = run;
    w.sseq   = s;
    w.stime  = t;
    w.sbytes = b;
    append_expected(w);
    body_count++;
  endfunction

  function automatic void build_report();
    report_word_t w;
    logic [SEQ_W-1:0] prev;
    logic [SEQ_W-1:0] gap;
    logic [63:0] losses;
    logic [63:0] q;
    logic [31:0] span;
    logic [RUN_W-1:0] consec;
    body_count = 0;
    losses = 0;
    span = 0;
    consec = 0;
    if (rec_count > 1) span = 32'(SEQ_W'(rec_seq[rec_count-1] - rec_seq[0] + 1'b1));
    if (rec_count > 0) begin
      prev = rec_seq[0] - 1'b1;
      for (int i = 0; i < rec_count; i++) begin
        gap = rec_seq[i] - prev;
        if (gap == 1) begin
          consec++;
          if (i == rec_count - 1) push_body(KIND_LOSS, consec, '0, '0, '0);
        end else begin
          push_body(KIND_LOSS, consec, '0, '0, '0);
          push_body(KIND_LOSS, RUN_W'(1) - RUN_W'(gap), '0, '0, '0);
          consec = 1;
          losses += 64'(SEQ_W'(gap - 1'b1));
        end
        prev = rec_seq[i];
      end
      for (int i = 0; i < rec_count; i++) begin
        if (seq_precedes(last_seq, rec_seq[i])) begin
          push_body(KIND_SAMPLE, '0, rec_seq[i], rec_time[i], rec_bytes[i]);
          last_seq = rec_seq[i];
        end
      end
    end
    w = '0;
    w.kind = KIND_SUMMARY;
    if (wlen == 0) begin
      w.thr = (win_bytes != 0) ? 32'hFFFF_FFFF : 32'h0;
    end else begin
      q = (64'(win_bytes) * 64'd8000) / 64'(wlen);
      w.thr = (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
    end
    if (span != 0) begin
      q = (losses << 16) / 64'(span);
      held_rate = (q > 64'd65536) ? RATE_ONE : q[RATE_W-1:0];
    end
    w.span = span[SEQ_W-1:0];
    w.loss = (losses > 64'd65535) ? 16'hFFFF : losses[SEQ_W-1:0];
    w.rate = held_rate;
    w.last = 1'b1;
    append_expected(w);
  endfunction

  function automatic void check_result();
    report_word_t got;
    report_word_t exp;
    got = '{kind_i, run_value_i, sample_seq_i, sample_time_i, sample_bytes_i,
            packet_span_i, loss_count_i, throughput_i, loss_rate_q16_i, last_i};
    results++;
    if (pending_results.size() == 0) begin
      errors++;
      if (errors <= 10) $display("Result transfer with nothing expected: kind %0d", got.kind);
      return;
    end
    exp = pending_results[0];
    pending_results.delete(0);
    if (got !== exp) begin
      errors++;
      if (errors <= 10) begin
        $display("Mismatch: expected kind %0d run %0h seq %0d time %0d bytes %0d span %0d",
                 exp.kind, exp.run, exp.sseq, exp.stime, exp.sbytes, exp.span);
        $display("  loss %0d thr %0d rate %0d last %0b", exp.loss, exp.thr, exp.rate, exp.last);
        $display("  got kind %0d run %0h seq %0d time %0d bytes %0d span %0d",
                 got.kind, got.run, got.sseq, got.stime, got.sbytes, got.span);
        $display("  loss %0d thr %0d rate %0d last %0b", got.loss, got.thr, got.rate, got.last);
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_count = 0;
      win_bytes = '0;
      last_seq  = LAST_SEQ_RESET;
      held_rate = '0;
      wlen      = WLEN_RESET;
      errors    = 0;
      results   = 0;
      reports   = 0;
      pending_results.delete();
    end else begin
      if (out_valid_i && out_ready_i) check_result();
      if (cfg_we_i) wlen = cfg_wdata_i;
      if (in_valid_i && in_ready_i) begin
        if (mode_i == MODE_REPORT) begin
          build_report();
          reports++;
        end else begin
          apply_arrival(seq_number_i, arrival_time_i, packet_bytes_i);
        end
      end
    end
    errors_o  <= errors;
    pending_o <= pending_results.size();
    results_o <= results;
    reports_o <= reports;
  end

endmodule

// File: test/tb.sv
// Testbench top for the receive window loss monitor: clock, reset, stimulus and verdict.
// Depends on rwlm_pkg, the block itself and rwlm_tb_monitor, which does all prediction.
`timescale 1ns / 1ps
module tb;
  import rwlm_pkg::*;
  import rwlm_tb_pkg::*;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [WLEN_W-1:0]  cfg_wdata_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic               mode_i = MODE_ARRIVAL;
  logic [SEQ_W-1:0]   seq_number_i = '0;
  logic [TIME_W-1:0]  arrival_time_i = '0;
  logic [BYTES_W-1:0] packet_bytes_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [1:0]         kind_o;
  logic [RUN_W-1:0]   run_value_o;
  logic [SEQ_W-1:0]   sample_seq_o;
  logic [TIME_W-1:0]  sample_time_o;
  logic [BYTES_W-1:0] sample_bytes_o;
  logic [SEQ_W-1:0]   packet_span_o;
  logic [SEQ_W-1:0]   loss_count_o;
  logic [TIME_W-1:0]  throughput_o;
  logic [RATE_W-1:0]  loss_rate_q16_o;
  logic               last_o;

  int  errors;
  int  pending;
  int  results;
  int  reports;
  int  items_sent = 0;
  int  cycles = 0;
  bit  no_gaps = 0;
  bit  hold_request = 0;
  logic [SEQ_W-1:0]  cur_seq;
  logic [TIME_W-1:0] cur_time;
  logic [WLEN_W-1:0] cur_wlen;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  receive_window_loss_monitor dut (.*);

  rwlm_tb_monitor chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_i(in_ready_o), .mode_i, .seq_number_i, .arrival_time_i,
    .packet_bytes_i, .out_valid_i(out_valid_o), .out_ready_i, .kind_i(kind_o),
    .run_value_i(run_value_o), .sample_seq_i(sample_seq_o), .sample_time_i(sample_time_o),
    .sample_bytes_i(sample_bytes_o), .packet_span_i(packet_span_o),
    .loss_count_i(loss_count_o), .throughput_i(throughput_o),
    .loss_rate_q16_i(loss_rate_q16_o), .last_i(last_o),
    .errors_o(errors), .pending_o(pending), .results_o(results), .reports_o(reports)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("Timeout with %0d results still expected.", pending);
      $display("FAIL receive_window_loss_monitor");
      $finish;
    end
  end

  // Result side: a random hold-off before each transfer, and one long stall on request.
  initial begin
    int k;
    @(posedge rst_ni);
    forever begin
      k = no_gaps ? 0 : $urandom_range(0, 9);
      if (hold_request) begin
        hold_request = 0;
        k = 1500;
      end
      if (k > 0) begin
        out_ready_i <= 1'b0;
        repeat (k) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
    end
  end

  task automatic offer(logic m, logic [SEQ_W-1:0] s, logic [TIME_W-1:0] t,
                       logic [BYTES_W-1:0] b);
    int k;
    k = no_gaps ? 0 : $urandom_range(0, 9);
    if (k > 0) begin
      in_valid_i <= 1'b0;
      repeat (k) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    mode_i         <= m;
    seq_number_i   <= s;
    arrival_time_i <= t;
    packet_bytes_i <= b;
    do @(posedge clk_i); while (!(in_valid_i && in_ready_o));
    items_sent++;
  endtask

  task automatic settle_and_write(logic [WLEN_W-1:0] v);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cur_wlen = v;
  endtask

  task automatic random_item();
    int r;
    logic [BYTES_W-1:0] b;
    logic [SEQ_W-1:0] s;
    if ($urandom_range(0, 7) == 0) begin
      offer(MODE_REPORT, SEQ_W'($urandom), $urandom, BYTES_W'($urandom));
      return;
    end
    r = $urandom_range(0, 99);
    if (r < 70) begin
      cur_seq = cur_seq + SEQ_W'(1 + (($urandom_range(0, 4) == 0) ? $urandom_range(1, 5) : 0));
      s = cur_seq;
    end else if (r < 80) begin
      s = cur_seq - SEQ_W'($urandom_range(0, 6));
    end else if (r < 90) begin
      s = SEQ_W'($urandom);
    end else begin
      s = cur_seq + 16'h8000;
    end
    r = $urandom_range(0, 99);
    if (r < 5) cur_time = $urandom;
    else if (r < 10) cur_time = cur_time + cur_wlen + 2;
    else cur_time = cur_time + $urandom_range(0, cur_wlen / 20);
    r = $urandom_range(0, 9);
    b = (r == 0) ? 16'hFFFF : (r == 1) ? 16'h0 : BYTES_W'($urandom);
    offer(MODE_ARRIVAL, s, cur_time, b);
  endtask

  initial begin
    logic [WLEN_W-1:0] windows[4];
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    cur_wlen = WLEN_RESET;

    // Empty store, unorderable number, wrapped ordering, duplicate, trailing gap.
    offer(MODE_REPORT, 16'h0, 32'h0, 16'h0);
    offer(MODE_ARRIVAL, 16'h0000, 32'h0, 16'h0);
    offer(MODE_ARRIVAL, 16'h8000, 32'h5, 16'hFFFF);
    offer(MODE_REPORT, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
    offer(MODE_ARRIVAL, 16'hFFFF, 32'h10, 16'hFFFF);
    offer(MODE_ARRIVAL, 16'h0005, 32'h20, 16'h1234);
    offer(MODE_ARRIVAL, 16'h0000, 32'h30, 16'h0100);
    offer(MODE_REPORT, 16'h0, 32'h0, 16'h0);
    offer(MODE_ARRIVAL, 16'h0003, 32'h40, 16'h0001);
    offer(MODE_ARRIVAL, 16'h0004, 32'h50, 16'h0002);
    offer(MODE_ARRIVAL, 16'h0006, 32'h60, 16'h0003);
    offer(MODE_REPORT, 16'h0, 32'h0, 16'h0);
    offer(MODE_ARRIVAL, 16'h0007, 32'hFFFF_FFFF, 16'hAAAA);
    offer(MODE_REPORT, 16'h0, 32'h0, 16'h0);

    windows[0] = 24'd1;
    windows[1] = 24'd10000000;
    windows[2] = WLEN_RESET;
    windows[3] = WLEN_W'($urandom_range(1, 10000000));
    for (int p = 0; p < 4; p++) begin
      settle_and_write(windows[p]);
      cur_seq  = SEQ_W'($urandom);
      cur_time = $urandom;
      for (int n = 0; n < 100; n++) begin
        if (n % 25 == 0) no_gaps = ($urandom_range(0, 3) == 0);
        if (p == 2 && n == 10) hold_request = 1;
        random_item();
      end
    end
    no_gaps = 0;
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    $display("Sent %0d items (%0d reports) over four window settings;", items_sent, reports);
    $display("checked %0d results, %0d mismatches.", results, errors);
    if (errors == 0) begin
      $display("PASS receive_window_loss_monitor");
    end else begin
      $display("FAIL receive_window_loss_monitor");
    end
    $finish;
  end

endmodule
